FILE: src/macd_indicator_core_defines.svh
// Assertion macros shared by the MACD indicator RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef MACD_INDICATOR_CORE_DEFINES_SVH
`define MACD_INDICATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MACD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MACD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define MACD_ASSERT(label, clk, rst_n, prop, msg)
`define MACD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

FILE: src/macd_pkg.sv
// Types and constants of the MACD indicator core.
// Depends on nothing; used by every other file of the block but the assertion macro header.
`timescale 1ns / 1ps
package macd_pkg;
    localparam int PRICE_W   = 40;
    localparam int VAL_W     = 41;
    localparam int HIST_W    = 43;
    localparam int AVG_W     = 48;
    localparam int SUM_W     = 56;
    localparam int PER_W     = 8;
    localparam int DEN_W     = 9;
    localparam int ALPHA_W   = 33;
    localparam int ACC_W     = 77;
    localparam int IDX_W     = 2;
    localparam int STEP_W    = 6;
    localparam int DIV_STEPS = 56;

    localparam logic [IDX_W-1:0] CFG_FAST   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SLOW   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SIGNAL = 2'd2;

    localparam logic [1:0] LANE_FAST   = 2'd0;
    localparam logic [1:0] LANE_SLOW   = 2'd1;
    localparam logic [1:0] LANE_SIGNAL = 2'd2;

    localparam logic [PER_W-1:0] FAST_RESET   = 8'd12;
    localparam logic [PER_W-1:0] SLOW_RESET   = 8'd26;
    localparam logic [PER_W-1:0] SIGNAL_RESET = 8'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ALPHA,
        ST_MUL,
        ST_SEED,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DEN_W-1:0]    den;
    } div_ctrl_t;
endpackage

FILE: src/macd_if.sv
// Valid/ready channel interfaces for price beats and result beats.
// Depends on macd_pkg for the field widths.
`timescale 1ns / 1ps
interface macd_price_if;
    logic                               valid;
    logic                               ready;
    logic [macd_pkg::PRICE_W-1:0]       close_price;
    modport source (output valid, output close_price, input ready);
    modport sink (input valid, input close_price, output ready);
endinterface

interface macd_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [macd_pkg::VAL_W-1:0]  dif_value;
    logic                               dif_valid;
    logic signed [macd_pkg::VAL_W-1:0]  dea_value;
    logic                               dea_valid;
    logic signed [macd_pkg::HIST_W-1:0] hist_value;
    modport source (output valid, output dif_value, output dif_valid, output dea_value,
                    output dea_valid, output hist_value, input ready);
    modport sink (input valid, input dif_value, input dif_valid, input dea_value,
                  input dea_valid, input hist_value, output ready);
endinterface

FILE: src/macd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on macd_pkg for widths and the control struct.
`timescale 1ns / 1ps
module macd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  macd_pkg::div_ctrl_t           ctrl,
    input  logic [macd_pkg::SUM_W-1:0]    num,
    output logic                          done,
    output logic [macd_pkg::SUM_W-1:0]    quot
);
    logic [macd_pkg::SUM_W-1:0]  num_reg, num_next;
    logic [macd_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [macd_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [macd_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [macd_pkg::DEN_W:0]    trial;
    logic                        qbit;

    always_comb
    begin
        trial     = {rem_reg, num_reg[macd_pkg::SUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            num_next  = num;
            rem_next  = '0;
            den_next  = ctrl.den;
            cnt_next  = macd_pkg::STEP_W'(macd_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[macd_pkg::SUM_W-2:0], qbit};
            rem_next = qbit ? macd_pkg::DEN_W'(trial - {1'b0, den_reg})
                            : trial[macd_pkg::DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;
endmodule

FILE: src/macd_indicator_core.sv
// MACD indicator core: top level with the sequencer and the serial multiplier.
// Depends on macd_pkg, macd_if, macd_div and the assertion macro header.
`timescale 1ns / 1ps
`include "macd_indicator_core_defines.svh"
// One closing price beat gives one result beat. The three averages are worked
// one after another through a single shared bit-serial divider (used for the
// smoothing factor and for the seed mean) and a bit-serial multiplier. A new
// price is taken once the previous result has been placed in the output
// register, which holds it until taken.
module macd_indicator_core #(
    parameter int PERIOD_MAX = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [macd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [macd_pkg::PER_W-1:0]   cfg_data,
    macd_price_if.sink                   price_ch,
    macd_result_if.source                result_ch
);
    localparam int AW = macd_pkg::AVG_W;
    localparam int SW = macd_pkg::SUM_W;

    macd_pkg::state_t state_reg, state_next;

    logic [macd_pkg::PER_W-1:0]   per_reg [3];
    logic signed [AW-1:0]         avg_reg [3], avg_next [3];
    logic signed [SW-1:0]         sum_reg [3], sum_next [3];
    logic [macd_pkg::PER_W-1:0]   cnt_reg [3], cnt_next [3];
    logic [2:0]                   flag_reg, flag_next;
    logic [1:0]                   lane_reg, lane_next;
    logic [macd_pkg::PRICE_W-1:0] price_reg, price_next;
    logic signed [AW-1:0]         dif_reg, dif_next;
    logic signed [AW-1:0]         d_reg, d_next;
    logic signed [macd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [macd_pkg::ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [macd_pkg::STEP_W-1:0]  mcnt_reg, mcnt_next;
    logic                         neg_reg, neg_next;

    logic                         ov_reg, ov_next;
    logic signed [macd_pkg::VAL_W-1:0]  o_dif_reg, o_dif_next;
    logic signed [macd_pkg::VAL_W-1:0]  o_dea_reg, o_dea_next;
    logic signed [macd_pkg::HIST_W-1:0] o_hist_reg, o_hist_next;
    logic                         o_dv_reg, o_dv_next;
    logic                         o_ev_reg, o_ev_next;

    macd_pkg::div_ctrl_t          div_ctrl;
    logic [SW-1:0]                div_num;
    logic                         div_done;
    logic [SW-1:0]                div_quot;

    logic [macd_pkg::PER_W-1:0]   per_eff;
    logic signed [AW-1:0]         x_cur;
    logic signed [SW-1:0]         sum_new;
    logic [macd_pkg::PER_W:0]     cnt_inc;
    logic                         out_free;
    logic signed [AW-1:0]         hist_wide;

    macd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        per_eff = per_reg[lane_reg];
        if ({8'd0, per_eff} > 16'(PERIOD_MAX))
        begin
            per_eff = macd_pkg::PER_W'(PERIOD_MAX);
        end
        x_cur = (lane_reg == macd_pkg::LANE_SIGNAL) ? dif_reg
                                                    : AW'($signed({1'b0, price_reg}));
        sum_new  = sum_reg[lane_reg] + SW'(x_cur);
        cnt_inc  = {1'b0, cnt_reg[lane_reg]} + 1'b1;
        out_free = !ov_reg || result_ch.ready;
        hist_wide = (dif_reg - avg_reg[2]) <<< 1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            macd_pkg::ST_IDLE:
                if (price_ch.valid)
                begin
                    state_next = macd_pkg::ST_EVAL;
                end
            macd_pkg::ST_EVAL:
                if (lane_reg == macd_pkg::LANE_SIGNAL && !(flag_reg[0] && flag_reg[1]))
                begin
                    state_next = macd_pkg::ST_OUT;
                end
                else if (per_eff == '0)
                begin
                    state_next = macd_pkg::ST_NEXT;
                end
                else if (cnt_reg[lane_reg] >= per_eff)
                begin
                    state_next = macd_pkg::ST_ALPHA;
                end
                else if (cnt_inc == {1'b0, per_eff})
                begin
                    state_next = macd_pkg::ST_SEED;
                end
                else
                begin
                    state_next = macd_pkg::ST_NEXT;
                end
            macd_pkg::ST_ALPHA:
                if (div_done)
                begin
                    state_next = macd_pkg::ST_MUL;
                end
            macd_pkg::ST_MUL:
                if (mcnt_reg == '0)
                begin
                    state_next = macd_pkg::ST_NEXT;
                end
            macd_pkg::ST_SEED:
                if (div_done)
                begin
                    state_next = macd_pkg::ST_NEXT;
                end
            macd_pkg::ST_NEXT:
                state_next = (lane_reg == macd_pkg::LANE_SIGNAL) ? macd_pkg::ST_OUT
                                                                 : macd_pkg::ST_EVAL;
            macd_pkg::ST_OUT:
                if (out_free)
                begin
                    state_next = macd_pkg::ST_IDLE;
                end
            default:
                state_next = macd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        avg_next    = avg_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        flag_next   = flag_reg;
        lane_next   = lane_reg;
        price_next  = price_reg;
        dif_next    = dif_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        alpha_next  = alpha_reg;
        mcnt_next   = mcnt_reg;
        neg_next    = neg_reg;
        ov_next     = ov_reg && !result_ch.ready;
        o_dif_next  = o_dif_reg;
        o_dea_next  = o_dea_reg;
        o_hist_next = o_hist_reg;
        o_dv_next   = o_dv_reg;
        o_ev_next   = o_ev_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.den   = {1'b0, per_eff} + 1'b1;
        div_num   = (SW'(1) << 33) + SW'(({1'b0, per_eff} + 1'b1) >> 1);
        case (state_reg)
            macd_pkg::ST_IDLE:
                if (price_ch.valid)
                begin
                    price_next = price_ch.close_price;
                    lane_next  = macd_pkg::LANE_FAST;
                end
            macd_pkg::ST_EVAL:
                if (lane_reg == macd_pkg::LANE_SIGNAL && !(flag_reg[0] && flag_reg[1]))
                begin
                    flag_next[2] = 1'b0;
                end
                else if (per_eff == '0)
                begin
                    flag_next[lane_reg] = 1'b0;
                end
                else if (cnt_reg[lane_reg] >= per_eff)
                begin
                    div_ctrl.start = 1'b1;
                end
                else
                begin
                    sum_next[lane_reg] = sum_new;
                    cnt_next[lane_reg] = cnt_inc[macd_pkg::PER_W-1:0];
                    flag_next[lane_reg] = 1'b0;
                    if (cnt_inc == {1'b0, per_eff})
                    begin
                        div_ctrl.start = 1'b1;
                        div_ctrl.den   = {1'b0, per_eff};
                        div_num  = sum_new[SW-1] ? SW'(-sum_new) : SW'(sum_new);
                        neg_next = sum_new[SW-1];
                    end
                end
            macd_pkg::ST_ALPHA:
                if (div_done)
                begin
                    alpha_next = div_quot[macd_pkg::ALPHA_W-1:0];
                    d_next     = x_cur - avg_reg[lane_reg];
                    acc_next   = '0;
                    mcnt_next  = macd_pkg::STEP_W'(macd_pkg::ALPHA_W);
                end
            macd_pkg::ST_MUL:
                if (mcnt_reg == '0)
                begin
                    avg_next[lane_reg] = avg_reg[lane_reg]
                        + AW'($signed(acc_reg[macd_pkg::ACC_W-1:32]));
                    flag_next[lane_reg] = 1'b1;
                end
                else
                begin
                    acc_next = (acc_reg <<< 1)
                        + (alpha_reg[macd_pkg::ALPHA_W-1] ? macd_pkg::ACC_W'(d_reg) : '0);
                    alpha_next = alpha_reg << 1;
                    mcnt_next  = mcnt_reg - 1'b1;
                end
            macd_pkg::ST_SEED:
                if (div_done)
                begin
                    avg_next[lane_reg] = neg_reg ? -AW'(div_quot) : AW'(div_quot);
                    flag_next[lane_reg] = 1'b1;
                end
            macd_pkg::ST_NEXT:
            begin
                if (lane_reg == macd_pkg::LANE_SLOW)
                begin
                    dif_next = avg_reg[0] - avg_reg[1];
                end
                if (lane_reg != macd_pkg::LANE_SIGNAL)
                begin
                    lane_next = lane_reg + 1'b1;
                end
            end
            macd_pkg::ST_OUT:
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    o_dv_next  = flag_reg[0] && flag_reg[1];
                    o_ev_next  = flag_reg[0] && flag_reg[1] && flag_reg[2];
                    o_dif_next = (flag_reg[0] && flag_reg[1])
                               ? dif_reg[macd_pkg::VAL_W-1:0] : '0;
                    o_dea_next = (flag_reg[0] && flag_reg[1] && flag_reg[2])
                               ? avg_reg[2][macd_pkg::VAL_W-1:0] : '0;
                    o_hist_next = (flag_reg[0] && flag_reg[1] && flag_reg[2])
                                ? hist_wide[macd_pkg::HIST_W-1:0] : '0;
                end
            default:
                ov_next = ov_reg && !result_ch.ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= macd_pkg::ST_IDLE;
            per_reg[0] <= macd_pkg::FAST_RESET;
            per_reg[1] <= macd_pkg::SLOW_RESET;
            per_reg[2] <= macd_pkg::SIGNAL_RESET;
            for (int i = 0; i < 3; i++)
            begin
                avg_reg[i] <= '0;
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            flag_reg <= '0;
            lane_reg <= macd_pkg::LANE_FAST;
            ov_reg   <= 1'b0;
            mcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            avg_reg   <= avg_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            flag_reg  <= flag_next;
            lane_reg  <= lane_next;
            ov_reg    <= ov_next;
            mcnt_reg  <= mcnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    macd_pkg::CFG_FAST:   per_reg[0] <= cfg_data;
                    macd_pkg::CFG_SLOW:   per_reg[1] <= cfg_data;
                    macd_pkg::CFG_SIGNAL: per_reg[2] <= cfg_data;
                    default:              per_reg[0] <= per_reg[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg  <= price_next;
        dif_reg    <= dif_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        alpha_reg  <= alpha_next;
        neg_reg    <= neg_next;
        o_dif_reg  <= o_dif_next;
        o_dea_reg  <= o_dea_next;
        o_hist_reg <= o_hist_next;
        o_dv_reg   <= o_dv_next;
        o_ev_reg   <= o_ev_next;
    end

    assign price_ch.ready       = (state_reg == macd_pkg::ST_IDLE);
    assign result_ch.valid      = ov_reg;
    assign result_ch.dif_value  = o_dif_reg;
    assign result_ch.dif_valid  = o_dv_reg;
    assign result_ch.dea_value  = o_dea_reg;
    assign result_ch.dea_valid  = o_ev_reg;
    assign result_ch.hist_value = o_hist_reg;

    `MACD_ASSERT(a_dea_needs_dif, clk, rst_n, (!ov_reg || !o_ev_reg || o_dv_reg), "dea valid without dif valid")
    `MACD_ASSERT_NEXT(a_accept_busy, clk, rst_n, (price_ch.valid && price_ch.ready), (state_reg == macd_pkg::ST_EVAL), "accepted beat not taken into work")
    `MACD_ASSERT(a_div_done_wait, clk, rst_n, (!div_done || state_reg == macd_pkg::ST_ALPHA || state_reg == macd_pkg::ST_SEED), "divider finished outside a wait state")
endmodule

FILE: bench/macd_indicator_core_test.sv
// Self-checking bench for the MACD indicator core: drives price beats, predicts
// each result beat in a scoreboard class and compares it field by field.
// Depends on macd_pkg, the channel interfaces in macd_if and the core itself.
`timescale 1ns / 1ps
module macd_indicator_core_test;
    localparam int PERIOD_CAP  = 255;
    localparam int DOG_LIMIT   = 20000;
    localparam int SETTLE_WAIT = 400;

    typedef struct {
        logic [macd_pkg::VAL_W-1:0]  dif;
        logic                        dif_ok;
        logic [macd_pkg::VAL_W-1:0]  dea;
        logic                        dea_ok;
        logic [macd_pkg::HIST_W-1:0] hist;
    } macd_beat_t;

    class macd_scoreboard;
        int          period [3];
        longint      avg [3];
        longint      seed [3];
        int          cnt [3];
        macd_beat_t  pending [$];

        function new();
            period[0] = macd_pkg::FAST_RESET;
            period[1] = macd_pkg::SLOW_RESET;
            period[2] = macd_pkg::SIGNAL_RESET;
            for (int i = 0; i < 3; i++)
            begin
                avg[i] = 0;
                seed[i] = 0;
                cnt[i] = 0;
            end
        endfunction

        function longint smooth(longint d, longint unsigned a);
            logic [64:0] m;
            logic [64:0] r;
            m = (d < 0) ? 65'(-d) : 65'(d);
            r = (m[63:32] * a) + ((65'(m[31:0]) * a + (d < 0 ? 65'hFFFF_FFFF : 65'd0)) >> 32);
            return (d < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
        endfunction

        function bit average_step(int lane, longint x);
            longint          p;
            longint unsigned a;
            p = period[lane] > PERIOD_CAP ? PERIOD_CAP : period[lane];
            if (p == 0)
                return 0;
            if (cnt[lane] >= p)
            begin
                a = ((64'd1 << 33) + (p + 1) / 2) / (p + 1);
                avg[lane] = avg[lane] + smooth(x - avg[lane], a);
                return 1;
            end
            seed[lane] += x;
            cnt[lane]++;
            if (cnt[lane] == p)
            begin
                avg[lane] = seed[lane] / p;
                return 1;
            end
            return 0;
        endfunction

        function void note_price(logic [macd_pkg::PRICE_W-1:0] price);
            macd_beat_t e;
            longint     x;
            longint     dif;
            longint     dea;
            bit         fv;
            bit         sv;
            x = longint'({24'd0, price});
            fv = average_step(0, x);
            sv = average_step(1, x);
            dif = 0;
            dea = 0;
            e.dea_ok = 0;
            e.dif_ok = fv && sv;
            if (e.dif_ok)
            begin
                dif = avg[0] - avg[1];
                e.dea_ok = average_step(2, dif);
                if (e.dea_ok)
                    dea = avg[2];
            end
            e.dif = dif[macd_pkg::VAL_W-1:0];
            e.dea = dea[macd_pkg::VAL_W-1:0];
            e.hist = e.dea_ok ? 43'(2 * (dif - dea)) : '0;
            pending.push_back(e);
        endfunction

        function string check_result(macd_beat_t got);
            macd_beat_t e;
            if (pending.size() == 0)
                return "result beat with no price outstanding";
            e = pending.pop_front();
            if (got.dif !== e.dif || got.dif_ok !== e.dif_ok || got.dea !== e.dea
                || got.dea_ok !== e.dea_ok || got.hist !== e.hist)
                return $sformatf("got dif %h/%b dea %h/%b hist %h, want %h/%b %h/%b %h",
                    got.dif, got.dif_ok, got.dea, got.dea_ok, got.hist,
                    e.dif, e.dif_ok, e.dea, e.dea_ok, e.hist);
            return "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [macd_pkg::IDX_W-1:0] cfg_index;
    logic [macd_pkg::PER_W-1:0] cfg_data;
    int   errors;
    int   idle_pct;
    int   quiet;
    macd_scoreboard sb;

    macd_price_if  price_ch ();
    macd_result_if result_ch ();

    macd_indicator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .price_ch  (price_ch.sink),
        .result_ch (result_ch.source)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        macd_beat_t got;
        string      msg;
        if (rst_n && price_ch.valid && price_ch.ready)
            sb.note_price(price_ch.close_price);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.dif = result_ch.dif_value;
            got.dif_ok = result_ch.dif_valid;
            got.dea = result_ch.dea_value;
            got.dea_ok = result_ch.dea_valid;
            got.hist = result_ch.hist_value;
            msg = sb.check_result(got);
            if (msg != "")
                report(msg);
        end
        if ((price_ch.valid && price_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= DOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        result_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);

    task send_price(logic [macd_pkg::PRICE_W-1:0] p);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            price_ch.valid <= 0;
            @(negedge clk);
        end
        price_ch.valid <= 1;
        price_ch.close_price <= p;
        @(posedge clk);
        while (!price_ch.ready)
            @(posedge clk);
    endtask

    task write_periods(logic [macd_pkg::PER_W-1:0] fp, logic [macd_pkg::PER_W-1:0] sp,
                       logic [macd_pkg::PER_W-1:0] gp);
        @(negedge clk);
        price_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= macd_pkg::CFG_FAST;
        cfg_data <= fp;
        @(negedge clk);
        cfg_index <= macd_pkg::CFG_SLOW;
        cfg_data <= sp;
        @(negedge clk);
        cfg_index <= macd_pkg::CFG_SIGNAL;
        cfg_data <= gp;
        @(negedge clk);
        cfg_we <= 0;
        sb.period[0] = fp;
        sb.period[1] = sp;
        sb.period[2] = gp;
    endtask

    function logic [macd_pkg::PER_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 8'd0;
        if (r < 12)
            return 8'd1;
        if (r < 16)
            return 8'd255;
        return 8'($urandom_range(30, 2));
    endfunction

    function logic [macd_pkg::PRICE_W-1:0] wide_price();
        return macd_pkg::PRICE_W'({$urandom, $urandom});
    endfunction

    initial
    begin
        logic [macd_pkg::PRICE_W-1:0] walk;
        int sent;
        int n;
        int mode;
        sb = new();
        errors = 0;
        quiet = 0;
        idle_pct = 36;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = macd_pkg::CFG_FAST;
        cfg_data = '0;
        price_ch.valid = 0;
        price_ch.close_price = '0;
        result_ch.ready = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part: extremes, a period of one, a zero period and a change mid-seed.
        send_price('1);
        send_price('0);
        write_periods(8'd1, 8'd1, 8'd1);
        send_price('1);
        send_price('0);
        send_price('1);
        send_price(40'h00_0001_0000);
        write_periods(8'd0, 8'd2, 8'd1);
        send_price('1);
        send_price('0);
        send_price(40'h55_5555_5555);
        write_periods(8'd3, 8'd1, 8'd0);
        send_price('0);
        send_price('1);
        send_price('1);
        send_price('0);
        write_periods(8'd1, 8'd6, 8'd255);
        send_price('1);
        send_price(40'hAA_AAAA_AAAA);
        write_periods(8'd1, 8'd2, 8'd2);
        send_price('1);
        send_price('0);
        send_price('1);

        sent = 0;
        walk = 40'h00_6400_0000;
        while (sent < 1000)
        begin
            write_periods(pick_period(), pick_period(), pick_period());
            n = $urandom_range(120, 30);
            mode = $urandom_range(3);
            idle_pct = ($urandom_range(4) == 0) ? 0 : 36;
            repeat (n)
            begin
                if (mode == 0)
                    send_price(wide_price());
                else if (mode == 1)
                    send_price($urandom_range(1) ? '1 : '0);
                else
                begin
                    walk = walk + macd_pkg::PRICE_W'($urandom_range(20000))
                         - macd_pkg::PRICE_W'(10000);
                    send_price($urandom_range(9) == 0 ? wide_price() : walk);
                end
                sent++;
            end
        end
        idle_pct = 36;
        @(negedge clk);
        price_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
